// ----- src/ggvr_pkg.sv -----
// shared constants, widths and tables for the gravity vector rotate unit
package ggvr_pkg;

    // fixed point formats
    localparam int VEC_FRAC     = 14;                 // fraction bits of the stored vector
    localparam int Q_FRAC       = 30;                 // internal fraction bits
    localparam int CORDIC_STEPS = 16;                 // cordic iterations

    // request opcodes
    localparam logic OP_ROTATE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // datapath widths
    localparam int FIELD_W  = 16;
    localparam int MUL_W    = 40;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int MUL_CW   = $clog2(MUL_W);
    localparam int DIV_NW   = 64;
    localparam int DIV_DW   = 48;
    localparam int DIV_CW   = $clog2(DIV_NW);
    localparam int SQ_W     = 64;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int SQ_CW    = $clog2(ROOT_W);
    localparam int ANG_W    = 32;
    localparam int CS_W     = 34;
    localparam int CA_W     = 33;
    localparam int CORDIC_CW = $clog2(CORDIC_STEPS);
    localparam int MAG_W    = 24;

    // apb register map
    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] ADDR_STEP_TIME = '0;
    localparam logic [FIELD_W-1:0] STEP_TIME_RST = 16'd10000;

    // angle scaling: deg/s * 2^12 * us * 2^20 / 360e6 gives a binary angle
    localparam logic [DIV_NW-1:0] ANGLE_DEN  = 64'd360000000;
    localparam logic [DIV_NW-1:0] ANGLE_HALF = 64'd180000000;
    localparam int ANGLE_SH = 20;
    localparam int AXIS_SH  = 38;

    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [MUL_W-1:0] ONE_Q = 40'sd1 <<< Q_FRAC;

    // rounding back to the vector format when the norm is zero
    localparam int NN_SH = Q_FRAC - VEC_FRAC;
    localparam logic signed [MUL_W-1:0] NN_HALF =
        (NN_SH > 0) ? (40'sd1 <<< ((NN_SH > 0) ? NN_SH - 1 : 0)) : 40'sd0;

    localparam logic signed [FIELD_W-1:0] UP_ONE =
        (VEC_FRAC >= 15) ? 16'sd32767 : FIELD_W'(32'sd1 <<< VEC_FRAC);

    // atan(2^-i) in turns * 2^32
    localparam logic [29:0] ATAN_TURNS [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465, 30'd10680862, 30'd5340245, 30'd2670163, 30'd1335087,
        30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
        30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
        30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
    };

endpackage

// ----- src/ggvr_mul.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
module ggvr_mul (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [ggvr_pkg::MUL_W-1:0]      i_a,
    input  logic signed [ggvr_pkg::MUL_W-1:0]      i_b,
    output logic                                   o_done,
    output logic signed [ggvr_pkg::PROD_W-1:0]     o_prod
);
    localparam int W = ggvr_pkg::MUL_W;

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [ggvr_pkg::MUL_CW-1:0] r_cnt;
    logic [W-1:0]     r_mcand;
    logic [2*W-1:0]   r_p;
    logic [W:0]       n_sum;
    logic [W-1:0]     a_mag;
    logic [W-1:0]     b_mag;

    assign a_mag = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign b_mag = i_b[W-1] ? W'(-i_b) : W'(i_b);
    assign n_sum = {1'b0, r_p[2*W-1:W]} + (r_p[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_mcand <= a_mag;
                r_p     <= {{W{1'b0}}, b_mag};
                r_neg   <= i_a[W-1] ^ i_b[W-1];
            end else if (r_busy) begin
                r_p <= {n_sum, r_p[W-1:1]};
                if (r_cnt == ggvr_pkg::MUL_CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_neg ? -$signed(r_p) : $signed(r_p);
endmodule

// ----- src/ggvr_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module ggvr_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ggvr_pkg::DIV_NW-1:0]     i_num,
    input  logic [ggvr_pkg::DIV_DW-1:0]     i_den,
    output logic                            o_done,
    output logic [ggvr_pkg::DIV_NW-1:0]     o_quo
);
    localparam int NW = ggvr_pkg::DIV_NW;
    localparam int DW = ggvr_pkg::DIV_DW;

    logic             r_busy;
    logic             r_done;
    logic [ggvr_pkg::DIV_CW-1:0] r_cnt;
    logic [DW-1:0]    r_den;
    logic [DW:0]      r_rem;
    logic [NW-1:0]    r_q;
    logic [DW:0]      n_trial;
    logic             n_fit;

    assign n_trial = {r_rem[DW-1:0], r_q[NW-1]};
    assign n_fit   = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_den  <= i_den;
                r_rem  <= '0;
                r_q    <= i_num;
            end else if (r_busy) begin
                r_rem <= n_fit ? n_trial - {1'b0, r_den} : n_trial;
                r_q   <= {r_q[NW-2:0], n_fit};
                if (r_cnt == ggvr_pkg::DIV_CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ----- src/ggvr_sqrt.sv -----
// digit-by-digit floor square root, one root bit per cycle
module ggvr_sqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ggvr_pkg::SQ_W-1:0]       i_val,
    output logic                            o_done,
    output logic [ggvr_pkg::ROOT_W-1:0]     o_root
);
    localparam int SW = ggvr_pkg::SQ_W;
    localparam int RW = ggvr_pkg::ROOT_W;

    logic             r_busy;
    logic             r_done;
    logic [ggvr_pkg::SQ_CW-1:0] r_cnt;
    logic [SW-1:0]    r_val;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [RW+1:0]    n_t;
    logic [RW+1:0]    n_trial;
    logic             n_fit;

    assign n_t     = {r_rem[RW-1:0], r_val[SW-1:SW-2]};
    assign n_trial = {r_root, 2'b01};
    assign n_fit   = n_t >= n_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val  <= {r_val[SW-3:0], 2'b00};
                r_rem  <= n_fit ? n_t - n_trial : n_t;
                r_root <= {r_root[RW-2:0], n_fit};
                if (r_cnt == ggvr_pkg::SQ_CW'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ----- src/ggvr_cordic.sv -----
// rotation-mode cordic, one micro-rotation per cycle
module ggvr_cordic (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [ggvr_pkg::ANG_W-1:0]            i_ang,
    output logic                                  o_done,
    output logic signed [ggvr_pkg::CS_W-1:0]      o_cos,
    output logic signed [ggvr_pkg::CS_W-1:0]      o_sin
);
    localparam int AW = ggvr_pkg::CA_W;
    localparam logic signed [AW-1:0] QUARTER = 33'sd1 <<< 30;
    localparam logic signed [AW-1:0] HALF    = 33'sd1 <<< 31;

    logic                          r_busy;
    logic                          r_done;
    logic                          r_neg;
    logic [ggvr_pkg::CORDIC_CW-1:0] r_cnt;
    logic signed [ggvr_pkg::CS_W-1:0] r_x;
    logic signed [ggvr_pkg::CS_W-1:0] r_y;
    logic signed [AW-1:0]          r_a;
    logic signed [AW-1:0]          a_in;
    logic signed [ggvr_pkg::CS_W-1:0] n_xs;
    logic signed [ggvr_pkg::CS_W-1:0] n_ys;
    logic signed [AW-1:0]          n_at;

    assign a_in = AW'($signed(i_ang));
    assign n_xs = r_x >>> r_cnt;
    assign n_ys = r_y >>> r_cnt;
    assign n_at = AW'(ggvr_pkg::ATAN_TURNS[5'(r_cnt)]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_x    <= ggvr_pkg::CORDIC_GAIN;
                r_y    <= '0;
                // fold into +-quarter turn, a half turn negates both outputs
                priority if (a_in > QUARTER) begin
                    r_a   <= a_in - HALF;
                    r_neg <= 1'b1;
                end else if (a_in < -QUARTER) begin
                    r_a   <= a_in + HALF;
                    r_neg <= 1'b1;
                end else begin
                    r_a   <= a_in;
                    r_neg <= 1'b0;
                end
            end else if (r_busy) begin
                if (!r_a[AW-1]) begin
                    r_x <= r_x - n_ys;
                    r_y <= r_y + n_xs;
                    r_a <= r_a - n_at;
                end else begin
                    r_x <= r_x + n_ys;
                    r_y <= r_y - n_xs;
                    r_a <= r_a + n_at;
                end
                if (r_cnt == ggvr_pkg::CORDIC_CW'(ggvr_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_neg ? -r_x : r_x;
    assign o_sin  = r_neg ? -r_y : r_y;
endmodule

// ----- src/gyro_gravity_vector_rotate_unit.sv -----
// top level: ground-up vector tracker, rotates the vector by gyro samples
//
//  port group      dir  handshake               payload
//  apb config      in   psel/penable/pwrite     paddr, pwdata -> step_time_us, prdata back
//  request in      in   i_in_valid/o_in_ready   i_opcode, i_rate_*, i_load_*
//  result out      out  o_out_valid/i_out_ready o_up_x/y/z, o_skipped
//
//  one request at a time. a load goes straight to the done state, an all-zero rate stops
//  after the three squares, and a rotate runs, one after another, 28 products on the
//  bit-serial multiplier, 7 quotients on the restoring divider, two square roots and a
//  cordic (a zero norm skips the last 3 quotients); the done state then fills the output
//  register.
//  a waiting result holds the next one in the done state; reset: vector up, dt 10000.
module gyro_gravity_vector_rotate_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ggvr_pkg::APB_AW-1:0]           paddr,
    input  logic [ggvr_pkg::APB_DW-1:0]           pwdata,
    output logic [ggvr_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_opcode,
    input  logic signed [ggvr_pkg::FIELD_W-1:0]   i_rate_x,
    input  logic signed [ggvr_pkg::FIELD_W-1:0]   i_rate_y,
    input  logic signed [ggvr_pkg::FIELD_W-1:0]   i_rate_z,
    input  logic signed [ggvr_pkg::FIELD_W-1:0]   i_load_x,
    input  logic signed [ggvr_pkg::FIELD_W-1:0]   i_load_y,
    input  logic signed [ggvr_pkg::FIELD_W-1:0]   i_load_z,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [ggvr_pkg::FIELD_W-1:0]   o_up_x,
    output logic signed [ggvr_pkg::FIELD_W-1:0]   o_up_y,
    output logic signed [ggvr_pkg::FIELD_W-1:0]   o_up_z,
    output logic                                  o_skipped
);
    localparam int FW = ggvr_pkg::FIELD_W;
    localparam int MW = ggvr_pkg::MUL_W;

    // sequencer steps, in order of a rotate
    typedef enum logic [3:0] {
        ST_IDLE,     // waiting for a request
        ST_SQ,       // sum of squared rates
        ST_ROOT_W,   // rate magnitude
        ST_MDT,      // magnitude times step time
        ST_ANG,      // binary angle
        ST_CORDIC,   // sin and cos
        ST_AXIS,     // unit axis, one component per quotient
        ST_KV,       // dot and cross products of axis and vector
        ST_ROT,      // rodrigues sum per component
        ST_NORM,     // squared norm
        ST_ROOT_N,   // norm
        ST_OUT,      // normalize each component
        ST_DONE      // hand the result to the output register
    } t_state;

    t_state                  r_state;
    logic                    r_issue;      // start pulse for the unit of this step
    logic [3:0]              r_idx;
    logic [1:0]              r_ph;
    logic [FW-1:0]           r_step_time;
    logic signed [FW-1:0]    r_up [3];
    logic signed [FW-1:0]    r_w [3];
    logic [31:0]             r_sum;
    logic [ggvr_pkg::MAG_W-1:0] r_mag;
    logic [ggvr_pkg::ANG_W-1:0] r_ang;
    logic signed [ggvr_pkg::CS_W-1:0] r_c;
    logic signed [ggvr_pkg::CS_W-1:0] r_s;
    logic signed [31:0]      r_k [3];
    logic signed [MW-1:0]    r_dot;
    logic signed [MW-1:0]    r_cr [3];
    logic signed [MW-1:0]    r_t;
    logic signed [MW-1:0]    r_r [3];
    logic [63:0]             r_nsum;
    logic [ggvr_pkg::ROOT_W-1:0] r_n;
    logic                    r_skip;
    logic                    r_out_valid;
    logic signed [FW-1:0]    r_out [3];
    logic                    r_out_skip;

    // unit hookups
    logic                           mul_start, mul_done;
    logic signed [MW-1:0]           mul_a, mul_b;
    logic signed [ggvr_pkg::PROD_W-1:0] mul_prod;
    logic signed [MW-1:0]           p30;
    logic                           div_start, div_done;
    logic [ggvr_pkg::DIV_NW-1:0]    div_num, div_quo;
    logic [ggvr_pkg::DIV_DW-1:0]    div_den;
    logic                           sq_start, sq_done;
    logic [ggvr_pkg::SQ_W-1:0]      sq_val;
    logic [ggvr_pkg::ROOT_W-1:0]    sq_root;
    logic                           cor_start, cor_done;
    logic signed [ggvr_pkg::CS_W-1:0] cor_cos, cor_sin;

    logic [1:0]              ix;
    logic [1:0]              ka, vb;
    logic signed [MW-1:0]    v_sel;
    logic signed [MW-1:0]    omc;
    logic [FW-1:0]           w_abs;
    logic [MW-1:0]           r_abs;
    logic                    in_take;
    logic                    out_free;
    logic [31:0]             sum_next;
    logic                    n_issue;

    // axis and vector index for the nine axis-vector products
    function automatic logic [1:0] kv_ka(input logic [3:0] j);
        unique case (j)
            4'd0, 4'd6, 4'd7: kv_ka = 2'd0;
            4'd1, 4'd3, 4'd8: kv_ka = 2'd1;
            default:          kv_ka = 2'd2;
        endcase
    endfunction

    function automatic logic [1:0] kv_vb(input logic [3:0] j);
        unique case (j)
            4'd0, 4'd5, 4'd8: kv_vb = 2'd0;
            4'd1, 4'd4, 4'd7: kv_vb = 2'd1;
            default:          kv_vb = 2'd2;
        endcase
    endfunction

    function automatic logic signed [FW-1:0] sat_q(input logic neg,
                                                   input logic [ggvr_pkg::DIV_NW-1:0] q);
        if (!neg) begin
            sat_q = (q > 64'd32767) ? 16'sd32767 : $signed(q[FW-1:0]);
        end else begin
            sat_q = (q > 64'd32768) ? -16'sd32768 : $signed(FW'(-q[FW-1:0]));
        end
    endfunction

    function automatic logic signed [FW-1:0] sat_s(input logic signed [MW-1:0] x);
        priority if (x > 40'sd32767) begin
            sat_s = 16'sd32767;
        end else if (x < -40'sd32768) begin
            sat_s = -16'sd32768;
        end else begin
            sat_s = x[FW-1:0];
        end
    endfunction

    function automatic logic signed [MW-1:0] vec_q(input logic signed [FW-1:0] u);
        vec_q = MW'(u) <<< ggvr_pkg::NN_SH;
    endfunction

    assign ix       = r_idx[1:0];
    assign ka       = kv_ka(r_idx);
    assign vb       = kv_vb(r_idx);
    assign p30      = MW'(mul_prod >>> ggvr_pkg::Q_FRAC);
    assign omc      = ggvr_pkg::ONE_Q - MW'(r_c);
    assign w_abs    = r_w[ix][FW-1] ? FW'(-r_w[ix]) : FW'(r_w[ix]);
    assign r_abs    = r_r[ix][MW-1] ? MW'(-r_r[ix]) : MW'(r_r[ix]);
    assign v_sel    = vec_q(r_up[vb]);
    assign in_take  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign sum_next = r_sum + mul_prod[31:0];

    // operand selection for the shared units
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_num = '0;
        div_den = '0;
        sq_val  = '0;
        unique case (r_state)
            ST_SQ: begin
                mul_a = MW'(r_w[ix]);
                mul_b = MW'(r_w[ix]);
            end
            ST_MDT: begin
                mul_a = $signed(MW'(r_mag));
                mul_b = $signed(MW'(r_step_time));
            end
            ST_KV: begin
                mul_a = MW'(r_k[ka]);
                mul_b = v_sel;
            end
            ST_ROT: begin
                unique case (r_ph)
                    2'd0: begin
                        mul_a = vec_q(r_up[ix]);
                        mul_b = MW'(r_c);
                    end
                    2'd1: begin
                        mul_a = r_cr[ix];
                        mul_b = MW'(r_s);
                    end
                    2'd2: begin
                        mul_a = MW'(r_k[ix]);
                        mul_b = r_dot;
                    end
                    default: begin
                        mul_a = r_t;
                        mul_b = omc;
                    end
                endcase
            end
            ST_NORM: begin
                mul_a = r_r[ix] >>> 10;
                mul_b = r_r[ix] >>> 10;
            end
            ST_ANG: begin
                // magnitude times step time is unsigned and may use the top bit
                div_num = (ggvr_pkg::DIV_NW'($unsigned(r_t)) << ggvr_pkg::ANGLE_SH)
                        + ggvr_pkg::ANGLE_HALF;
                div_den = ggvr_pkg::DIV_DW'(ggvr_pkg::ANGLE_DEN);
            end
            ST_AXIS: begin
                div_num = ggvr_pkg::DIV_NW'(w_abs) << ggvr_pkg::AXIS_SH;
                div_den = ggvr_pkg::DIV_DW'(r_mag);
            end
            ST_OUT: begin
                // round half away: (|r| * 2^F + den/2) / den with den = n * 2^10
                div_num = (ggvr_pkg::DIV_NW'(r_abs) << ggvr_pkg::VEC_FRAC)
                        + (ggvr_pkg::DIV_NW'(r_n) << 9);
                div_den = ggvr_pkg::DIV_DW'(r_n) << 10;
            end
            ST_ROOT_W: sq_val = ggvr_pkg::SQ_W'(r_sum) << 16;
            ST_ROOT_N: sq_val = r_nsum;
            default: ;
        endcase
    end

    // start the next unit whenever a step hands over to one
    always_comb begin
        unique case (r_state)
            ST_IDLE:   n_issue = in_take && (i_opcode == ggvr_pkg::OP_ROTATE);
            ST_SQ:     n_issue = mul_done && !(r_idx == 4'd2 && sum_next == '0);
            ST_ROOT_W: n_issue = sq_done;
            ST_ROOT_N: n_issue = sq_done && (sq_root != '0);
            ST_MDT, ST_KV, ST_ROT, ST_NORM: n_issue = mul_done;
            ST_ANG, ST_AXIS: n_issue = div_done;
            ST_CORDIC: n_issue = cor_done;
            ST_OUT:    n_issue = div_done && (r_idx != 4'd2);
            default:   n_issue = 1'b0;
        endcase
    end

    assign mul_start = r_issue && (r_state == ST_SQ || r_state == ST_MDT ||
                                   r_state == ST_KV || r_state == ST_ROT ||
                                   r_state == ST_NORM);
    assign div_start = r_issue && (r_state == ST_ANG || r_state == ST_AXIS ||
                                   r_state == ST_OUT);
    assign sq_start  = r_issue && (r_state == ST_ROOT_W || r_state == ST_ROOT_N);
    assign cor_start = r_issue && (r_state == ST_CORDIC);

    ggvr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ggvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    ggvr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (sq_val),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    ggvr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_ang   (r_ang),
        .o_done  (cor_done),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

    // sequencer, vector state, config register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issue     <= 1'b0;
            r_out_valid <= 1'b0;
            r_step_time <= ggvr_pkg::STEP_TIME_RST;
            r_up[0]     <= '0;
            r_up[1]     <= '0;
            r_up[2]     <= ggvr_pkg::UP_ONE;
        end else begin
            r_issue <= n_issue;

            if (psel && penable && pwrite && paddr == ggvr_pkg::ADDR_STEP_TIME) begin
                r_step_time <= pwdata[FW-1:0];
            end

            // the done state refills the output register itself
            if (r_out_valid && i_out_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_idx  <= '0;
                        r_skip <= 1'b0;
                        if (i_opcode == ggvr_pkg::OP_LOAD) begin
                            // load stores the vector as given
                            r_up[0] <= i_load_x;
                            r_up[1] <= i_load_y;
                            r_up[2] <= i_load_z;
                            r_state <= ST_DONE;
                        end else begin
                            r_w[0]  <= i_rate_x;
                            r_w[1]  <= i_rate_y;
                            r_w[2]  <= i_rate_z;
                            r_sum   <= '0;
                            r_state <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    if (mul_done) begin
                        r_sum <= sum_next;
                        if (r_idx == 4'd2) begin
                            if (sum_next == '0) begin
                                // zero rate keeps the vector
                                r_skip  <= 1'b1;
                                r_state <= ST_DONE;
                            end else begin
                                r_state <= ST_ROOT_W;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_ROOT_W: begin
                    if (sq_done) begin
                        r_mag   <= sq_root[ggvr_pkg::MAG_W-1:0];
                        r_state <= ST_MDT;
                    end
                end
                ST_MDT: begin
                    if (mul_done) begin
                        r_t     <= mul_prod[MW-1:0];
                        r_state <= ST_ANG;
                    end
                end
                ST_ANG: begin
                    if (div_done) begin
                        // whole turns drop out
                        r_ang   <= div_quo[ggvr_pkg::ANG_W-1:0];
                        r_state <= ST_CORDIC;
                    end
                end
                ST_CORDIC: begin
                    if (cor_done) begin
                        r_c     <= cor_cos;
                        r_s     <= cor_sin;
                        r_idx   <= '0;
                        r_state <= ST_AXIS;
                    end
                end
                ST_AXIS: begin
                    if (div_done) begin
                        // axis is -w/|w|, truncated toward zero
                        r_k[ix] <= r_w[ix][FW-1] ? $signed(div_quo[31:0])
                                                 : -$signed(div_quo[31:0]);
                        if (r_idx == 4'd2) begin
                            r_idx   <= '0;
                            r_dot   <= '0;
                            r_cr[0] <= '0;
                            r_cr[1] <= '0;
                            r_cr[2] <= '0;
                            r_state <= ST_KV;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_KV: begin
                    if (mul_done) begin
                        unique case (r_idx)
                            4'd0, 4'd1, 4'd2: r_dot <= r_dot + p30;
                            4'd3:    r_cr[0] <= r_cr[0] + p30;
                            4'd4:    r_cr[0] <= r_cr[0] - p30;
                            4'd5:    r_cr[1] <= r_cr[1] + p30;
                            4'd6:    r_cr[1] <= r_cr[1] - p30;
                            4'd7:    r_cr[2] <= r_cr[2] + p30;
                            default: r_cr[2] <= r_cr[2] - p30;
                        endcase
                        if (r_idx == 4'd8) begin
                            r_idx   <= '0;
                            r_ph    <= '0;
                            r_state <= ST_ROT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_ROT: begin
                    if (mul_done) begin
                        // v*c + (k x v)*s + k*(k.v)*(1-c)
                        unique case (r_ph)
                            2'd0:    r_r[ix] <= p30;
                            2'd1:    r_r[ix] <= r_r[ix] + p30;
                            2'd2:    r_t     <= p30;
                            default: r_r[ix] <= r_r[ix] + p30;
                        endcase
                        r_ph <= r_ph + 1'b1;
                        if (r_ph == 2'd3) begin
                            if (r_idx == 4'd2) begin
                                r_idx   <= '0;
                                r_nsum  <= '0;
                                r_state <= ST_NORM;
                            end else begin
                                r_idx <= r_idx + 1'b1;
                            end
                        end
                    end
                end
                ST_NORM: begin
                    if (mul_done) begin
                        r_nsum <= r_nsum + mul_prod[63:0];
                        if (r_idx == 4'd2) begin
                            r_state <= ST_ROOT_N;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_ROOT_N: begin
                    if (sq_done) begin
                        r_n   <= sq_root;
                        r_idx <= '0;
                        if (sq_root == '0) begin
                            // degenerate norm: round back without normalizing
                            r_up[0] <= sat_s((r_r[0] + ggvr_pkg::NN_HALF) >>> ggvr_pkg::NN_SH);
                            r_up[1] <= sat_s((r_r[1] + ggvr_pkg::NN_HALF) >>> ggvr_pkg::NN_SH);
                            r_up[2] <= sat_s((r_r[2] + ggvr_pkg::NN_HALF) >>> ggvr_pkg::NN_SH);
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    if (div_done) begin
                        r_up[ix] <= sat_q(r_r[ix][MW-1], div_quo);
                        if (r_idx == 4'd2) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out[0]    <= r_up[0];
                        r_out[1]    <= r_up[1];
                        r_out[2]    <= r_up[2];
                        r_out_skip  <= r_skip;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_up_x      = r_out[0];
    assign o_up_y      = r_out[1];
    assign o_up_z      = r_out[2];
    assign o_skipped   = r_out_skip;

    assign pready = 1'b1;
    assign prdata = (paddr == ggvr_pkg::ADDR_STEP_TIME) ?
                    ggvr_pkg::APB_DW'(r_step_time) : '0;
endmodule
